>>> rtl/olid_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// olid_pkg - shared types and codes for the ordered list core
// Opcodes, the per-operation route, and the command/status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package olid_pkg;

   localparam logic [1:0] OP_READ   = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;

   localparam int unsigned VAL_W = 32;
   localparam int unsigned POS_W = 7;
   localparam int unsigned LEN_W = 7;
   localparam int unsigned CAP_W = 7;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // what an accepted word turns into once its checks are done
   typedef enum logic [1:0] {
      ROUTE_ERR    = 2'd0,
      ROUTE_READ   = 2'd1,
      ROUTE_INSERT = 2'd2,
      ROUTE_DELETE = 2'd3
   } route_type;

   typedef struct packed {
      logic load;    // take the request word
      logic rd_pos;  // read the store at the request position
      logic fetch;   // capture read data as the result
      logic shift;   // one step of the element move
      logic emit;    // commit the update and load the response register
   } cmd_type;

   typedef struct packed {
      route_type route_now;  // route of the word on the request port
      route_type route_ff;   // route of the word in progress
      logic      shift_done; // no moves left and no write pending
   } stat_type;

endpackage
`default_nettype wire

>>> rtl/olid_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// olid_ctrl - sequencer for the ordered list core
// Walks each accepted word through those of read, element move and commit
// that its route needs, and owns the handshake of both channels.
// ----------------------------------------------------------------------------
module olid_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire olid_pkg::stat_type stat,
   output olid_pkg::cmd_type      cmd
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_READ  = 5'b00010,
      ST_FETCH = 5'b00100,
      ST_SHIFT = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               unique case (stat.route_now)
                  olid_pkg::ROUTE_ERR:    state_in = ST_EMIT;
                  olid_pkg::ROUTE_READ:   state_in = ST_READ;
                  olid_pkg::ROUTE_DELETE: state_in = ST_READ;
                  olid_pkg::ROUTE_INSERT: state_in = ST_SHIFT;
                  default:                state_in = ST_EMIT;
               endcase
            end
         end
         ST_READ: begin
            cmd.rd_pos = 1'b1;
            state_in   = ST_FETCH;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = (stat.route_ff == olid_pkg::ROUTE_DELETE) ? ST_SHIFT : ST_EMIT;
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            if (stat.shift_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/olid_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// olid_dpath - element store, count, capacity and response register
// One write and one registered read port on the store; inserts and deletes
// move one element per cycle through that port pair.
// ----------------------------------------------------------------------------
module olid_dpath #(
   parameter int DEPTH = 64
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic [1:0]                           req_opcode,
   input  wire logic signed [olid_pkg::POS_W-1:0]    req_position,
   input  wire logic signed [olid_pkg::VAL_W-1:0]    req_new_value,
   input  wire logic                                 csr_wr_en,
   input  wire logic [olid_pkg::CAP_W-1:0]           csr_wr_data,
   input  wire olid_pkg::cmd_type                    cmd,
   output olid_pkg::stat_type                        stat,
   output logic                                      rsp_status,
   output logic signed [olid_pkg::VAL_W-1:0]         rsp_result_value,
   output logic [olid_pkg::LEN_W-1:0]                rsp_list_length
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int LW = (CW > 7) ? CW : 7;

   logic [olid_pkg::VAL_W-1:0] mem [DEPTH];

   logic [CW-1:0]                cnt_ff, cnt_in, cnt_next;
   logic [olid_pkg::CAP_W-1:0]   cap_ff;
   olid_pkg::route_type          route_ff, route_now;
   logic [AW-1:0]                pos_addr_ff, ins_addr_ff;
   logic [olid_pkg::VAL_W-1:0]   val_ff, result_ff, rd_data_ff;
   logic [CW-1:0]                rem_ff, rem_in;
   logic [AW-1:0]                idx_ff, idx_in, last_ff, last_in;
   logic                         pend_ff, pend_in;

   logic                         rsp_status_ff;
   logic [olid_pkg::VAL_W-1:0]   rsp_result_ff;
   logic [olid_pkg::LEN_W-1:0]   rsp_length_ff;

   // request checks
   logic [LW-1:0] pos_u, cnt_l, cap_l, depth_l, cap_eff_l, mv_l, start_l, ins_l;
   logic          pos_neg, pos_front, pos_in_range, room;

   logic                       mem_re, mem_we, is_up, step_rd;
   logic [AW-1:0]              mem_raddr, mem_waddr;
   logic [olid_pkg::VAL_W-1:0] mem_wdata;
   logic [CW+6:0]              len_wide;

   assign pos_neg      = req_position[olid_pkg::POS_W-1];
   assign pos_front    = (req_position == '1);
   assign pos_u        = LW'(req_position[olid_pkg::POS_W-2:0]);
   assign cnt_l        = LW'(cnt_ff);
   assign cap_l        = LW'(cap_ff);
   assign depth_l      = LW'(DEPTH);
   assign cap_eff_l    = (cap_l > depth_l) ? depth_l : cap_l;
   assign pos_in_range = !pos_neg && (pos_u < cnt_l);
   assign room         = (cnt_l < cap_eff_l);

   always_comb begin
      unique case (req_opcode)
         olid_pkg::OP_READ:
            route_now = pos_in_range ? olid_pkg::ROUTE_READ : olid_pkg::ROUTE_ERR;
         olid_pkg::OP_INSERT:
            route_now = ((pos_in_range || pos_front) && room) ?
                        olid_pkg::ROUTE_INSERT : olid_pkg::ROUTE_ERR;
         olid_pkg::OP_DELETE:
            route_now = pos_in_range ? olid_pkg::ROUTE_DELETE : olid_pkg::ROUTE_ERR;
         default:
            route_now = olid_pkg::ROUTE_ERR;
      endcase
   end

   // elements to move: those after the position
   assign mv_l    = pos_front ? cnt_l : (cnt_l - pos_u - LW'(1));
   assign start_l = (req_opcode == olid_pkg::OP_INSERT) ? (cnt_l - LW'(1)) : (pos_u + LW'(1));
   assign ins_l   = pos_front ? '0 : (pos_u + LW'(1));

   assign stat.route_now  = route_now;
   assign stat.route_ff   = route_ff;
   assign stat.shift_done = (rem_ff == '0) && !pend_ff;

   // insert moves top-down into the next cell, delete bottom-up into the previous
   assign is_up   = (route_ff == olid_pkg::ROUTE_INSERT);
   assign step_rd = cmd.shift && (rem_ff != '0);

   assign mem_re    = cmd.rd_pos || step_rd;
   assign mem_raddr = cmd.rd_pos ? pos_addr_ff : idx_ff;
   assign mem_we    = (cmd.shift && pend_ff) || (cmd.emit && is_up);
   assign mem_waddr = cmd.emit ? ins_addr_ff : (is_up ? (last_ff + AW'(1)) : (last_ff - AW'(1)));
   assign mem_wdata = cmd.emit ? val_ff : rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   always_comb begin
      rem_in  = rem_ff;
      idx_in  = idx_ff;
      last_in = last_ff;
      pend_in = pend_ff;
      if (cmd.load) begin
         rem_in  = mv_l[CW-1:0];
         idx_in  = start_l[AW-1:0];
         pend_in = 1'b0;
      end else if (cmd.shift) begin
         pend_in = step_rd;
         if (step_rd) begin
            rem_in  = rem_ff - CW'(1);
            idx_in  = is_up ? (idx_ff - AW'(1)) : (idx_ff + AW'(1));
            last_in = idx_ff;
         end
      end
   end

   always_comb begin
      unique case (route_ff)
         olid_pkg::ROUTE_INSERT: cnt_next = cnt_ff + CW'(1);
         olid_pkg::ROUTE_DELETE: cnt_next = cnt_ff - CW'(1);
         default:                cnt_next = cnt_ff;
      endcase
   end

   assign cnt_in   = cmd.emit ? cnt_next : cnt_ff;
   assign len_wide = {7'd0, cnt_next};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         cap_ff   <= olid_pkg::CAP_RESET;
         route_ff <= olid_pkg::ROUTE_ERR;
         rem_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         rem_ff  <= rem_in;
         pend_ff <= pend_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         if (cmd.load) begin
            route_ff <= route_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      last_ff <= last_in;
      if (cmd.load) begin
         pos_addr_ff <= pos_u[AW-1:0];
         ins_addr_ff <= ins_l[AW-1:0];
         val_ff      <= req_new_value;
         result_ff   <= '0;
      end else if (cmd.fetch) begin
         result_ff <= rd_data_ff;
      end
      if (cmd.emit) begin
         rsp_status_ff <= (route_ff == olid_pkg::ROUTE_ERR);
         rsp_result_ff <= result_ff;
         rsp_length_ff <= len_wide[olid_pkg::LEN_W-1:0];
      end
   end

   assign rsp_status       = rsp_status_ff;
   assign rsp_result_value = rsp_result_ff;
   assign rsp_list_length  = rsp_length_ff;

endmodule
`default_nettype wire

>>> rtl/ordered_list_insert_delete_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_core - bounded ordered list of 32-bit words
// Read, insert-after and delete on a list held in one store, with a status,
// value and length returned for every request.
// ----------------------------------------------------------------------------
//  port group  dir  handshake            contents
//  req_        in   req_valid/req_ready  opcode, position, new_value
//  rsp_        out  rsp_valid/rsp_ready  status, result_value, list_length
//  csr_        in   csr_wr_en            list_capacity
//
//  One request at a time. Inserts and deletes move the elements after
//  the position one at a time through the store's single read and write
//  port pair.
//  A new request is taken while the previous response still waits on rsp_ready.
//  Synchronous reset empties the list and sets the capacity to 64.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_core #(
   parameter int DEPTH = 64
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [1:0]                           req_opcode,
   input  wire logic signed [olid_pkg::POS_W-1:0]    req_position,
   input  wire logic signed [olid_pkg::VAL_W-1:0]    req_new_value,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_status,
   output logic signed [olid_pkg::VAL_W-1:0]         rsp_result_value,
   output logic [olid_pkg::LEN_W-1:0]                rsp_list_length,
   input  wire logic                                 csr_wr_en,
   input  wire logic [olid_pkg::CAP_W-1:0]           csr_wr_data
);

   olid_pkg::cmd_type  cmd;
   olid_pkg::stat_type stat;

   olid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   olid_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_opcode       (req_opcode),
      .req_position     (req_position),
      .req_new_value    (req_new_value),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_status       (rsp_status),
      .rsp_result_value (rsp_result_value),
      .rsp_list_length  (rsp_list_length)
   );

   // busy in the cycle after taking a word
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while previous word still in progress");

   // the response register is only loaded when it is free or being drained
   a_emit_has_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid || rsp_ready))
      else $error("response overwritten before it was taken");

   // a failed request never returns data
   a_err_zero_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_result_value == '0))
      else $error("error response carries a non-zero value");

   // no element move while a new word could be taken
   a_shift_only_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.shift |-> !req_ready)
      else $error("element move outside a request");

endmodule
`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench - ordered list insert/delete core
// Drives read, insert and delete words through the req_ channel under random
// idling on both sides, mirrors the list in a local model, and checks every
// response word field by field. The capacity register is swept through
// several values between phases, the extremes among them.
// ----------------------------------------------------------------------------
module testbench;

   localparam int unsigned VAL_W = olid_pkg::VAL_W;
   localparam int unsigned POS_W = olid_pkg::POS_W;
   localparam int unsigned LEN_W = olid_pkg::LEN_W;
   localparam int unsigned CAP_W = olid_pkg::CAP_W;
   localparam logic [CAP_W-1:0] CAP_RESET = olid_pkg::CAP_RESET;
   localparam logic [1:0] OP_READ   = olid_pkg::OP_READ;
   localparam logic [1:0] OP_INSERT = olid_pkg::OP_INSERT;
   localparam logic [1:0] OP_DELETE = olid_pkg::OP_DELETE;

   localparam int DEPTH       = 64;
   localparam int STALL_LIMIT = 4000;
   localparam int LONG_HOLD   = 400;
   localparam int DRAIN_WAIT  = 8;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic                    status;
      logic signed [VAL_W-1:0] value;
      logic [LEN_W-1:0]        length;
   } list_reply_type;

   typedef enum logic [1:0] {
      ROW_OP  = 2'd0,
      ROW_CAP = 2'd1
   } row_kind_type;

   typedef struct packed {
      row_kind_type            kind;
      logic [1:0]              op;
      logic signed [POS_W-1:0] pos;
      logic signed [VAL_W-1:0] val;
      logic                    typed;
      list_reply_type          want;
   } plan_row_type;

   logic                    clock         = 1'b0;
   logic                    reset         = 1'b1;
   logic                    req_valid     = 1'b0;
   logic                    req_ready;
   logic [1:0]              req_opcode    = OP_READ;
   logic signed [POS_W-1:0] req_position  = '0;
   logic signed [VAL_W-1:0] req_new_value = '0;
   logic                    rsp_valid;
   logic                    rsp_ready     = 1'b0;
   logic                    rsp_status;
   logic signed [VAL_W-1:0] rsp_result_value;
   logic [LEN_W-1:0]        rsp_list_length;
   logic                    csr_wr_en     = 1'b0;
   logic [CAP_W-1:0]        csr_wr_data   = CAP_RESET;

   // mirror of the list
   logic signed [VAL_W-1:0] mirror_cells [DEPTH];
   int                      mirror_count = 0;
   int                      mirror_cap   = int'(CAP_RESET);

   list_reply_type pending_replies [$];
   int          error_count     = 0;
   bit          req_gaps_on     = 1'b1;
   bit          rsp_gaps_on     = 1'b1;
   int          rsp_hold_cycles = 0;

   // directed words; typed expectations only where obvious
   plan_row_type plan_rows [25] = '{
      '{ROW_OP,  OP_READ,   7'sd0,   32'sd0,        1'b1, '{1'b1, 32'sd0, 7'd0}},
      '{ROW_OP,  OP_DELETE, 7'sd0,   32'sd0,        1'b1, '{1'b1, 32'sd0, 7'd0}},
      '{ROW_OP,  OP_INSERT, 7'sd0,   32'sd5,        1'b1, '{1'b1, 32'sd0, 7'd0}},
      '{ROW_OP,  OP_INSERT, -7'sd1,  32'sh80000000, 1'b1, '{1'b0, 32'sd0, 7'd1}},
      '{ROW_OP,  OP_INSERT, 7'sd0,   32'sh7FFFFFFF, 1'b1, '{1'b0, 32'sd0, 7'd2}},
      '{ROW_OP,  OP_INSERT, -7'sd1,  32'shFFFFFFFF, 1'b1, '{1'b0, 32'sd0, 7'd3}},
      '{ROW_OP,  OP_READ,   7'sd0,   32'sd0,        1'b1, '{1'b0, 32'shFFFFFFFF, 7'd3}},
      '{ROW_OP,  OP_READ,   7'sd2,   32'sd0,        1'b1, '{1'b0, 32'sh7FFFFFFF, 7'd3}},
      '{ROW_OP,  OP_READ,   7'sd3,   32'sd0,        1'b1, '{1'b1, 32'sd0, 7'd3}},
      '{ROW_OP,  OP_READ,   -7'sd1,  32'sd0,        1'b1, '{1'b1, 32'sd0, 7'd3}},
      '{ROW_OP,  OP_INSERT, 7'sd63,  32'sd1,        1'b1, '{1'b1, 32'sd0, 7'd3}},
      '{ROW_OP,  OP_INSERT, 7'sh40,  32'sd1,        1'b1, '{1'b1, 32'sd0, 7'd3}},
      '{ROW_OP,  OP_UNUSED, 7'sd0,   32'sd7,        1'b1, '{1'b1, 32'sd0, 7'd3}},
      '{ROW_OP,  OP_DELETE, 7'sd1,   32'sd0,        1'b1, '{1'b0, 32'sh80000000, 7'd2}},
      '{ROW_OP,  OP_INSERT, 7'sd1,   32'sh55555555, 1'b0, '0},
      '{ROW_CAP, OP_READ,   7'sd0,   32'sd2,        1'b0, '0},
      '{ROW_OP,  OP_INSERT, -7'sd1,  32'sd9,        1'b1, '{1'b1, 32'sd0, 7'd3}},
      '{ROW_OP,  OP_READ,   7'sd1,   32'sd0,        1'b0, '0},
      '{ROW_OP,  OP_DELETE, 7'sd0,   32'sd0,        1'b0, '0},
      '{ROW_OP,  OP_INSERT, 7'sd0,   32'sd9,        1'b1, '{1'b1, 32'sd0, 7'd2}},
      '{ROW_OP,  OP_DELETE, 7'sd1,   32'sd0,        1'b0, '0},
      '{ROW_OP,  OP_INSERT, -7'sd1,  32'shAAAAAAAA, 1'b1, '{1'b0, 32'sd0, 7'd2}},
      '{ROW_CAP, OP_READ,   7'sd0,   32'sd0,        1'b0, '0},
      '{ROW_OP,  OP_INSERT, -7'sd1,  32'sd3,        1'b1, '{1'b1, 32'sd0, 7'd2}},
      '{ROW_OP,  OP_READ,   7'sd0,   32'sd0,        1'b0, '0}
   };

   ordered_list_insert_delete_core #(.DEPTH(DEPTH)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_position     (req_position),
      .req_new_value    (req_new_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_result_value (rsp_result_value),
      .rsp_list_length  (rsp_list_length),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #4 clock = ~clock;

   // applies one word to the mirror and returns the response it should give
   function automatic list_reply_type apply_list_op(logic [1:0] op,
                                                    logic signed [POS_W-1:0] pos_raw,
                                                    logic signed [VAL_W-1:0] val);
      int             p;
      int             j;
      int             room;
      list_reply_type r;
      p = pos_raw;
      room = (mirror_cap > DEPTH) ? DEPTH : mirror_cap;
      r = '0;
      r.status = 1'b1;
      case (op)
         OP_READ: begin
            if (p >= 0 && p < mirror_count) begin
               r.value  = mirror_cells[p];
               r.status = 1'b0;
            end
         end
         OP_INSERT: begin
            if (p >= -1 && p < mirror_count && mirror_count < room) begin
               for (j = mirror_count - 1; j > p; j--)
                  mirror_cells[j + 1] = mirror_cells[j];
               mirror_cells[p + 1] = val;
               mirror_count++;
               r.status = 1'b0;
            end
         end
         OP_DELETE: begin
            if (p >= 0 && p < mirror_count) begin
               r.value = mirror_cells[p];
               for (j = p + 1; j < mirror_count; j++)
                  mirror_cells[j - 1] = mirror_cells[j];
               mirror_count--;
               r.status = 1'b0;
            end
         end
         default: ;
      endcase
      r.length = LEN_W'(mirror_count);
      return r;
   endfunction

   task automatic report_mismatch(string note);
      $display("[%0t] mismatch: %s", $time, note);
      error_count++;
   endtask

   task automatic send_word(logic [1:0] op, logic signed [POS_W-1:0] pos,
                            logic signed [VAL_W-1:0] val, logic typed,
                            list_reply_type want);
      int             gap;
      list_reply_type model;
      gap = req_gaps_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_opcode    <= op;
      req_position  <= pos;
      req_new_value <= val;
      req_valid     <= 1'b1;
      do @(posedge clock); while (!req_ready);
      model = apply_list_op(op, pos, val);
      pending_replies.push_back(typed ? want : model);
   endtask

   // sender pauses until every response is back, then the list is idle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic set_capacity(int cap);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= CAP_W'(cap);
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      mirror_cap = cap;
   endtask

   task automatic run_phase(int cap, int n_words, int ins_pct, int del_pct,
                            bit req_gaps, bit rsp_gaps, bit hold);
      int                      k;
      int                      roll;
      int                      p;
      logic [1:0]              op;
      logic signed [POS_W-1:0] pos;
      logic signed [VAL_W-1:0] val;
      set_capacity(cap);
      req_gaps_on = req_gaps;
      rsp_gaps_on = rsp_gaps;
      if (hold)
         rsp_hold_cycles = LONG_HOLD;
      for (k = 0; k < n_words; k++) begin
         if ($urandom_range(0, 99) < 8) begin
            // noise: any opcode, any position
            op  = 2'($urandom_range(0, 3));
            pos = POS_W'($urandom);
            val = $urandom;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < ins_pct)
               op = OP_INSERT;
            else if (roll < ins_pct + del_pct)
               op = OP_DELETE;
            else
               op = OP_READ;
            if (op == OP_INSERT)
               p = int'($urandom_range(0, mirror_count)) - 1;
            else
               p = (mirror_count > 0) ? int'($urandom_range(0, mirror_count - 1)) : 0;
            if ($urandom_range(0, 7) == 0)
               p = (op == OP_INSERT) ? -1 : mirror_count - 1;
            pos = POS_W'(p);
            case ($urandom_range(0, 5))
               0:       val = 32'sh80000000;
               1:       val = 32'sh7FFFFFFF;
               2:       val = 32'sd0;
               3:       val = -32'sd1;
               default: val = $urandom;
            endcase
         end
         send_word(op, pos, val, 1'b0, '0);
      end
   endtask

   // receiver: random stalls, one long hold on request, checks each word
   initial begin : response_side
      int             stall;
      list_reply_type want;
      forever begin
         if (rsp_hold_cycles > 0)
            stall = rsp_hold_cycles;
         else
            stall = rsp_gaps_on ? $urandom_range(0, 9) : 0;
         rsp_hold_cycles = 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && !reset));
         if (pending_replies.size() == 0) begin
            report_mismatch("response word with nothing expected");
         end else begin
            want = pending_replies.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status expected %0d got %0d",
                                         want.status, rsp_status));
            if (rsp_result_value !== want.value)
               report_mismatch($sformatf("result_value expected %08h got %08h",
                                         want.value, rsp_result_value));
            if (rsp_list_length !== want.length)
               report_mismatch($sformatf("list_length expected %0d got %0d",
                                         want.length, rsp_list_length));
         end
      end
   end

   // ends the run if the handshakes go quiet for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      int r;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (r = 0; r < $size(plan_rows); r++) begin
         if (plan_rows[r].kind == ROW_CAP)
            set_capacity(int'(plan_rows[r].val));
         else
            send_word(plan_rows[r].op, plan_rows[r].pos, plan_rows[r].val,
                      plan_rows[r].typed, plan_rows[r].want);
      end

      // clamped capacity fills the store; low capacities leave extra words held
      run_phase(127, 120, 80, 10, 1'b1, 1'b1, 1'b0);
      run_phase(64,   60, 45, 45, 1'b0, 1'b0, 1'b0);
      run_phase(10,  100, 20, 60, 1'b0, 1'b1, 1'b1);
      run_phase(1,    60, 50, 40, 1'b1, 1'b1, 1'b0);
      run_phase(0,    40, 50, 30, 1'b1, 1'b0, 1'b0);
      run_phase(64,  120, 70, 20, 1'b0, 1'b1, 1'b0);
      run_phase(33,  100, 40, 40, 1'b1, 1'b1, 1'b0);
      run_phase(100, 190, 60, 30, 1'b1, 1'b0, 1'b0);
      run_phase(2,    90, 40, 50, 1'b1, 1'b1, 1'b0);

      wait_idle();
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

>>> ordered_list_insert_delete_core.f
rtl/olid_pkg.sv
rtl/olid_ctrl.sv
rtl/olid_dpath.sv
rtl/ordered_list_insert_delete_core.sv
tb/testbench.sv
